FILE: rtl/core/ocib_pkg.sv
// Shared types and constants for the octree cell index unit.
// Holds the register map and the per-axis configuration record; no dependencies.
`default_nettype none

package ocib_pkg;

    localparam int CFG_W = 32;

    typedef enum logic [2:0] {
        REG_LEVELS,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_INV_X,
        REG_INV_Y,
        REG_INV_Z
    } ocib_reg_t;

    localparam logic [2:0]  LEVELS_RESET = 3'd7;
    localparam logic [31:0] ORIGIN_RESET = 32'd0;
    localparam logic [31:0] INV_RESET    = 32'd65536;

    // origin is signed Q16.16 (two's complement), inv is unsigned Q16.16
    typedef struct packed {
        logic [31:0] origin;
        logic [31:0] inv;
    } ocib_axis_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/ocib_axis_quant.sv
// One axis: forms both box corners and quantizes them to finest-level cell coordinates.
// Four register stages: corner add, origin subtract, multiply, range check. Uses ocib_pkg.
`default_nettype none

module ocib_axis_quant #(
    parameter int MAX_LEVELS = 7,
    parameter int FRAC_BITS  = 16,
    localparam int LW = $clog2(MAX_LEVELS + 1)
) (
    input  wire logic                   clk,
    input  wire logic [31:0]            center,
    input  wire logic [30:0]            half,
    input  wire ocib_pkg::ocib_axis_cfg_t cfg,
    input  wire logic [LW-1:0]          lv,
    output logic [MAX_LEVELS-1:0]       cell_min,
    output logic [MAX_LEVELS-1:0]       cell_max,
    output logic                        ok
);
    import ocib_pkg::*;

    localparam int SH  = 2 * FRAC_BITS;
    localparam int PW  = 65;
    localparam int HPW = PW - SH;

    // index 0: min corner, index 1: max corner
    logic [32:0]            pos_reg   [2];
    logic [32:0]            pos_next  [2];
    logic [32:0]            d_reg     [2];
    logic [32:0]            d_next    [2];
    logic                   fail_reg  [2];
    logic                   fail_next [2];
    logic [63:0]            p0_reg    [2];
    logic [63:0]            p0_next   [2];
    logic [31:0]            p1_reg    [2];
    logic [31:0]            p1_next   [2];
    logic                   fail3_reg [2];
    logic [MAX_LEVELS-1:0]  cell_reg  [2];
    logic [MAX_LEVELS-1:0]  cell_next [2];
    logic                   ok_reg;
    logic                   ok_next;

    logic [33:0]            diff      [2];
    logic [32:0]            upper     [2];
    logic [PW-1:0]          prod      [2];
    logic [HPW-1:0]         hp        [2];
    logic                   in_range  [2];

    always_comb
    begin
        pos_next[0] = {center[31], center} - {2'b00, half};
        pos_next[1] = {center[31], center} + {2'b00, half};
        for (int c = 0; c < 2; c++)
        begin
            diff[c]      = {pos_reg[c][32], pos_reg[c]} - {{2{cfg.origin[31]}}, cfg.origin};
            // negative offset: outside, unless the reciprocal is zero (cell 0)
            d_next[c]    = diff[c][33] ? '0 : diff[c][32:0];
            fail_next[c] = diff[c][33] && (cfg.inv != '0);

            p0_next[c]   = 64'(d_reg[c][31:0]) * 64'(cfg.inv);
            p1_next[c]   = d_reg[c][32] ? cfg.inv : '0;

            upper[c]     = {1'b0, p0_reg[c][63:32]} + {1'b0, p1_reg[c]};
            prod[c]      = {upper[c], p0_reg[c][31:0]};
            hp[c]        = prod[c][PW-1:SH];
            in_range[c]  = ((hp[c] >> lv) == '0);
            cell_next[c] = hp[c][MAX_LEVELS-1:0];
        end
        ok_next = in_range[0] && in_range[1] && !fail3_reg[0] && !fail3_reg[1];
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            pos_reg[c]   <= pos_next[c];
            d_reg[c]     <= d_next[c];
            fail_reg[c]  <= fail_next[c];
            p0_reg[c]    <= p0_next[c];
            p1_reg[c]    <= p1_next[c];
            fail3_reg[c] <= fail_reg[c];
            cell_reg[c]  <= cell_next[c];
        end
        ok_reg <= ok_next;
    end

    assign cell_min = cell_reg[0];
    assign cell_max = cell_reg[1];
    assign ok       = ok_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ocib_index.sv
// Morton interleave, common-octant depth search and linear index with bound check.
// Two register stages after the quantizers; standalone, no package dependency.
`default_nettype none

module ocib_index #(
    parameter int MAX_LEVELS = 7,
    localparam int LW = $clog2(MAX_LEVELS + 1),
    localparam int MW = 3 * MAX_LEVELS,
    localparam int IW = 3 * MAX_LEVELS + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_vld,
    input  wire logic                         in_ok,
    input  wire logic [LW-1:0]                lv,
    input  wire logic [2:0][MAX_LEVELS-1:0]   cmin,
    input  wire logic [2:0][MAX_LEVELS-1:0]   cmax,
    output logic [21:0]                       cell_index,
    output logic [2:0]                        cell_depth,
    output logic                              index_valid
);

    logic [MW-1:0]  mmin;
    logic [MW-1:0]  mmax;
    logic [MW-1:0]  xdiff;
    logic [LW-1:0]  hi_next;
    logic [LW-1:0]  depth_next;
    logic [IW-1:0]  offset_next;
    logic [IW-1:0]  limit_next;

    logic [MW-1:0]  mmax_reg;
    logic [LW-1:0]  hi_reg;
    logic [LW-1:0]  depth_reg;
    logic [IW-1:0]  offset_reg;
    logic [IW-1:0]  limit_reg;
    logic           ok_reg;
    logic           vld_reg;

    logic [LW+1:0]  shamt;
    logic [MW-1:0]  shifted;
    logic [IW-1:0]  idx;
    logic           good;
    logic [21:0]    cell_index_next;
    logic [2:0]     cell_depth_next;
    logic           index_valid_next;
    logic [21:0]    cell_index_reg;
    logic [2:0]     cell_depth_reg;
    logic           index_valid_reg;

    always_comb
    begin
        for (int b = 0; b < MAX_LEVELS; b++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mmin[3*b+a] = cmin[a][b];
                mmax[3*b+a] = cmax[a][b];
            end
        end
        xdiff   = mmin ^ mmax;
        hi_next = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (i < int'(lv) && xdiff[3*i +: 3] != 3'b000)
            begin
                hi_next = LW'(i + 1);
            end
        end
        depth_next = lv - hi_next;
        // (8^d - 1) / 7 is the base-8 repunit 0o11..1
        offset_next = '0;
        limit_next  = '0;
        for (int k = 0; k <= MAX_LEVELS; k++)
        begin
            offset_next[3*k] = (k < int'(depth_next));
            limit_next[3*k]  = (k <= int'(lv));
        end
    end

    always_comb
    begin
        shamt            = (LW+2)'(hi_reg) * (LW+2)'(3);
        shifted          = mmax_reg >> shamt;
        idx              = {1'b0, shifted} + offset_reg;
        good             = ok_reg && (idx < limit_reg);
        cell_index_next  = good ? 22'(idx) : '0;
        cell_depth_next  = good ? 3'(depth_reg) : '0;
        index_valid_next = vld_reg && good;
    end

    always_ff @(posedge clk)
    begin
        mmax_reg       <= mmax;
        hi_reg         <= hi_next;
        depth_reg      <= depth_next;
        offset_reg     <= offset_next;
        limit_reg      <= limit_next;
        ok_reg         <= in_ok;
        cell_index_reg <= cell_index_next;
        cell_depth_reg <= cell_depth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= 1'b0;
            index_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg         <= in_vld;
            index_valid_reg <= index_valid_next;
        end
    end

    assign cell_index  = cell_index_reg;
    assign cell_depth  = cell_depth_reg;
    assign index_valid = index_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/octree_cell_index_of_box_unit.sv
// Octree cell index of a box: top level with configuration registers and valid pipeline.
// Uses ocib_pkg, ocib_axis_quant (three axes) and ocib_index.
//
// A box (center, half extent, Q16.16) is taken at every clock edge with start high;
// busy stays low, so one box per cycle is sustained. The result appears at the end of
// the pipeline on cell_index, cell_depth and index_valid, marked by done for one cycle,
// and the receiver cannot stall it. The six stages are corner add, origin subtract,
// 32x32 multiply (six multipliers, one per corner and axis), range check, Morton and
// depth search, and index add with bound check. Configuration registers are written
// through cfg_wr_en/cfg_addr/cfg_wr_data and must only change with no box in flight.
`default_nettype none

module octree_cell_index_of_box_unit #(
    parameter int MAX_LEVELS = 7,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [2:0]                 cfg_addr,
    input  wire logic [ocib_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [31:0]         center_x,
    input  wire logic signed [31:0]         center_y,
    input  wire logic signed [31:0]         center_z,
    input  wire logic [30:0]                half_x,
    input  wire logic [30:0]                half_y,
    input  wire logic [30:0]                half_z,
    output logic                            done,
    output logic [21:0]                     cell_index,
    output logic [2:0]                      cell_depth,
    output logic                            index_valid
);
    import ocib_pkg::*;

    localparam int LW    = $clog2(MAX_LEVELS + 1);
    localparam int DEPTH = 6;

    logic [2:0]             levels_reg;
    ocib_axis_cfg_t         axis_cfg_reg [3];
    logic [LW-1:0]          lv;
    logic [DEPTH-1:0]       vld_reg;
    logic [DEPTH-1:0]       vld_next;

    logic [2:0][31:0]               center;
    logic [2:0][30:0]               half;
    logic [2:0][MAX_LEVELS-1:0]     cmin;
    logic [2:0][MAX_LEVELS-1:0]     cmax;
    logic [2:0]                     ok_axis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
            for (int a = 0; a < 3; a++)
            begin
                axis_cfg_reg[a] <= '{origin: ORIGIN_RESET, inv: INV_RESET};
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_LEVELS:   levels_reg             <= cfg_wr_data[2:0];
                REG_ORIGIN_X: axis_cfg_reg[0].origin <= cfg_wr_data;
                REG_ORIGIN_Y: axis_cfg_reg[1].origin <= cfg_wr_data;
                REG_ORIGIN_Z: axis_cfg_reg[2].origin <= cfg_wr_data;
                REG_INV_X:    axis_cfg_reg[0].inv    <= cfg_wr_data;
                REG_INV_Y:    axis_cfg_reg[1].inv    <= cfg_wr_data;
                REG_INV_Z:    axis_cfg_reg[2].inv    <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(levels_reg) > MAX_LEVELS)
        begin
            lv = LW'(MAX_LEVELS);
        end
        else
        begin
            lv = LW'(levels_reg);
        end
    end

    // every cycle is a transfer slot; the pipeline never holds
    assign busy     = 1'b0;
    assign vld_next = {vld_reg[DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign center = {center_z, center_y, center_x};
    assign half   = {half_z, half_y, half_x};

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        ocib_axis_quant #(
            .MAX_LEVELS (MAX_LEVELS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_axis (
            .clk      (clk),
            .center   (center[a]),
            .half     (half[a]),
            .cfg      (axis_cfg_reg[a]),
            .lv       (lv),
            .cell_min (cmin[a]),
            .cell_max (cmax[a]),
            .ok       (ok_axis[a])
        );
    end

    ocib_index #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (vld_reg[DEPTH-3]),
        .in_ok       (&ok_axis),
        .lv          (lv),
        .cmin        (cmin),
        .cmax        (cmax),
        .cell_index  (cell_index),
        .cell_depth  (cell_depth),
        .index_valid (index_valid)
    );

    assign done = vld_reg[DEPTH-1];

    a_valid_only_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        index_valid |-> done)
        else $error("index_valid raised without a result transfer");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !index_valid) |-> (cell_index == '0 && cell_depth == '0))
        else $error("invalid result carries nonzero index or depth");

    a_done_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DEPTH-2] |=> done)
        else $error("result strobe lost in the last stage");

endmodule

`default_nettype wire

FILE: sim/octree_cell_index_of_box_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for octree_cell_index_of_box_unit: directed and random boxes checked against
// a behavioral model of the linear octree cell index, under several register settings.
// Depends on ocib_pkg and the octree_cell_index_of_box_unit RTL.

module octree_cell_index_of_box_unit_tb;
    import ocib_pkg::*;

    localparam int FRAC        = 16;
    localparam int MAX_LV      = 7;
    localparam int LATENCY     = 6;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic [30:0]        hz;
    } box_t;

    typedef struct packed {
        logic [21:0] idx;
        logic [2:0]  dep;
        logic        ok;
    } cell_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] center_x = '0;
    logic signed [31:0] center_y = '0;
    logic signed [31:0] center_z = '0;
    logic [30:0]        half_x = '0;
    logic [30:0]        half_y = '0;
    logic [30:0]        half_z = '0;
    logic               done;
    logic [21:0]        cell_index;
    logic [2:0]         cell_depth;
    logic               index_valid;

    // register copy seen by the predictor, updated on each write transfer
    logic [2:0]  lv_cfg = LEVELS_RESET;
    logic [31:0] org_cfg [3] = '{ORIGIN_RESET, ORIGIN_RESET, ORIGIN_RESET};
    logic [31:0] inv_cfg [3] = '{INV_RESET, INV_RESET, INV_RESET};

    // settings to load next
    logic [31:0] want_lv;
    logic [31:0] want_org [3];
    logic [31:0] want_inv [3];
    longint      ax_org [3];
    longint      ax_span [3];

    cell_t expected_cells [$];
    int    errors = 0;
    int    stall_cycles = 0;
    bit    gaps_on = 1'b1;

    octree_cell_index_of_box_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .done        (done),
        .cell_index  (cell_index),
        .cell_depth  (cell_depth),
        .index_valid (index_valid)
    );

    always #5 clk = ~clk;

    function automatic logic cell_coord(input longint pos, input logic [31:0] org,
                                        input logic [31:0] inv, input int lv,
                                        output logic [6:0] coord);
        longint       diff;
        logic [127:0] dw;
        logic [127:0] iw;
        logic [127:0] prod;
        coord = '0;
        diff = pos - longint'($signed(org));
        if (inv == 0)
            return 1'b1;
        if (diff < 0)
            return 1'b0;
        dw = 128'(diff);
        iw = 128'(inv);
        prod = dw * iw;
        if ((prod >> (2 * FRAC + lv)) != 0)
            return 1'b0;
        coord = prod[2 * FRAC +: 7];
        return 1'b1;
    endfunction

    function automatic logic [20:0] spread3(input logic [6:0] v);
        logic [20:0] r;
        r = '0;
        for (int b = 0; b < MAX_LV; b++)
            r[3 * b] = v[b];
        return r;
    endfunction

    function automatic logic [63:0] level_base(input int d);
        return ((64'd1 << (3 * d)) - 64'd1) / 64'd7;
    endfunction

    function automatic cell_t cell_of_box(input box_t b);
        longint      ctr [3];
        longint      half [3];
        logic [6:0]  cmin [3];
        logic [6:0]  cmax [3];
        logic        in_space;
        logic [20:0] mmin;
        logic [20:0] mmax;
        logic [20:0] split;
        int          lv;
        int          top;
        int          dep;
        logic [63:0] idx;
        cell_t       r;
        ctr[0] = longint'($signed(b.cx));
        ctr[1] = longint'($signed(b.cy));
        ctr[2] = longint'($signed(b.cz));
        half[0] = longint'({1'b0, b.hx});
        half[1] = longint'({1'b0, b.hy});
        half[2] = longint'({1'b0, b.hz});
        lv = int'(lv_cfg);
        if (lv > MAX_LV)
            lv = MAX_LV;
        in_space = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (!cell_coord(ctr[a] - half[a], org_cfg[a], inv_cfg[a], lv, cmin[a]))
                in_space = 1'b0;
            if (!cell_coord(ctr[a] + half[a], org_cfg[a], inv_cfg[a], lv, cmax[a]))
                in_space = 1'b0;
        end
        r = '0;
        if (!in_space)
            return r;
        mmin = spread3(cmin[0]) | (spread3(cmin[1]) << 1) | (spread3(cmin[2]) << 2);
        mmax = spread3(cmax[0]) | (spread3(cmax[1]) << 1) | (spread3(cmax[2]) << 2);
        split = mmin ^ mmax;
        top = 0;
        for (int i = 0; i < lv; i++)
            if (split[3 * i +: 3] != 3'd0)
                top = i + 1;
        dep = lv - top;
        idx = ({43'd0, mmax} >> (3 * top)) + level_base(dep);
        if (idx >= level_base(lv + 1))
            return r;
        r.idx = idx[21:0];
        r.dep = dep[2:0];
        r.ok  = 1'b1;
        return r;
    endfunction

    // model update, expectation on each box transfer, check on each result
    always @(posedge clk)
    begin : monitor
        cell_t exp_c;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (ocib_reg_t'(cfg_addr))
                    REG_LEVELS:   lv_cfg = cfg_wr_data[2:0];
                    REG_ORIGIN_X: org_cfg[0] = cfg_wr_data;
                    REG_ORIGIN_Y: org_cfg[1] = cfg_wr_data;
                    REG_ORIGIN_Z: org_cfg[2] = cfg_wr_data;
                    REG_INV_X:    inv_cfg[0] = cfg_wr_data;
                    REG_INV_Y:    inv_cfg[1] = cfg_wr_data;
                    REG_INV_Z:    inv_cfg[2] = cfg_wr_data;
                    default:      ;
                endcase
            end
            if (start && !busy)
                expected_cells = {expected_cells,
                                  cell_of_box(box_t'{center_x, center_y, center_z,
                                                     half_x, half_y, half_z})};
            if (done)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected result: index %0d depth %0d valid %0b",
                             $time, cell_index, cell_depth, index_valid);
                    errors++;
                end
                else
                begin
                    exp_c = expected_cells.pop_front();
                    if (cell_index !== exp_c.idx)
                    begin
                        $display("%0t: cell_index expected %0d, got %0d",
                                 $time, exp_c.idx, cell_index);
                        errors++;
                    end
                    if (cell_depth !== exp_c.dep)
                    begin
                        $display("%0t: cell_depth expected %0d, got %0d",
                                 $time, exp_c.dep, cell_depth);
                        errors++;
                    end
                    if (index_valid !== exp_c.ok)
                    begin
                        $display("%0t: index_valid expected %0b, got %0b",
                                 $time, exp_c.ok, index_valid);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_box(input box_t b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start    <= 1'b1;
        center_x <= b.cx;
        center_y <= b.cy;
        center_z <= b.cz;
        half_x   <= b.hx;
        half_y   <= b.hy;
        half_z   <= b.hz;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input ocib_reg_t r, input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= r;
        cfg_wr_data <= v;
        @(posedge clk);
    endtask

    task automatic load_space;
        drain();
        write_reg(REG_LEVELS, want_lv);
        write_reg(REG_ORIGIN_X, want_org[0]);
        write_reg(REG_ORIGIN_Y, want_org[1]);
        write_reg(REG_ORIGIN_Z, want_org[2]);
        write_reg(REG_INV_X, want_inv[0]);
        write_reg(REG_INV_Y, want_inv[1]);
        write_reg(REG_INV_Z, want_inv[2]);
        cfg_wr_en <= 1'b0;
    endtask

    // power-of-two cell sizes, sometimes slightly enlarged, space kept inside the number range
    task automatic set_space(input int lv);
        int     e;
        int     s;
        longint o;
        want_lv = ($urandom & 32'hFFFF_FFF8) | lv;
        for (int a = 0; a < 3; a++)
        begin
            e = $urandom_range(1, 30 - lv);
            ax_span[a] = longint'(1) << (e + lv);
            want_inv[a] = 32'd1 << (32 - e);
            if ($urandom_range(0, 2) == 0)
                want_inv[a] = want_inv[a] - $urandom_range(0, want_inv[a] >> 4);
            s = $urandom;
            o = longint'(s);
            if (o + ax_span[a] > 64'sd2147483647)
                o = o - ax_span[a];
            ax_org[a] = o;
            want_org[a] = o[31:0];
        end
    endtask

    function automatic box_t noise_box();
        box_t b;
        b.cx = $urandom;
        b.cy = $urandom;
        b.cz = $urandom;
        b.hx = 31'($urandom);
        b.hy = 31'($urandom);
        b.hz = 31'($urandom);
        return b;
    endfunction

    function automatic box_t box_in_space(input int lv);
        box_t        b;
        longint      lo [3];
        longint      hi [3];
        longint      c [3];
        longint      h [3];
        int unsigned span_m1;
        int unsigned sz;
        for (int a = 0; a < 3; a++)
        begin
            span_m1 = 32'(ax_span[a] - 1);
            lo[a] = ax_org[a] + longint'($urandom_range(0, span_m1));
            sz = 32'(ax_span[a] >> $urandom_range(0, lv + 2));
            hi[a] = lo[a] + longint'($urandom_range(0, sz));
            if (hi[a] >= ax_org[a] + ax_span[a])
                hi[a] = ax_org[a] + ax_span[a] - 1;
            c[a] = (lo[a] + hi[a]) >>> 1;
            h[a] = (hi[a] - lo[a]) >> 1;
        end
        b.cx = c[0][31:0];
        b.cy = c[1][31:0];
        b.cz = c[2][31:0];
        b.hx = h[0][30:0];
        b.hy = h[1][30:0];
        b.hz = h[2][30:0];
        return b;
    endfunction

    // reset settings: 7 levels, unit cells from the origin
    task automatic test_reset_config;
        send_box('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0, 31'h0, 31'h0});
        send_box('{32'h003F_8000, 32'h003F_8000, 32'h003F_8000,
                   31'h003F_8000, 31'h003F_8000, 31'h003F_8000});
        send_box('{32'h0040_0000, 32'h0040_0000, 32'h0040_0000,
                   31'h0040_0000, 31'h0040_0000, 31'h0040_0000});
        send_box('{32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF, 31'h0, 31'h0, 31'h0});
        send_box('{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 31'h0, 31'h0, 31'h0});
        send_box('{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 31'h0, 31'h0, 31'h0});
        send_box('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF});
        send_box('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   31'h7FFF_FFFF, 31'h0, 31'h0});
        send_box('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF});
        send_box('{32'h0040_0000, 32'h0040_0000, 32'h0040_0000,
                   31'h0001_0000, 31'h0001_0000, 31'h0001_0000});
        send_box('{32'h000C_0000, 32'h000C_0000, 32'h000C_0000,
                   31'h0003_8000, 31'h0003_8000, 31'h0003_8000});
        send_box('{32'h0005_0000, 32'h0064_0000, 32'h0000_8000, 31'h0, 31'h4000, 31'h8000});
    endtask

    // root cell only
    task automatic test_zero_levels;
        want_lv = 32'h0;
        for (int a = 0; a < 3; a++)
        begin
            want_org[a] = ORIGIN_RESET;
            want_inv[a] = INV_RESET;
        end
        load_space();
        send_box('{32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                   31'h4000, 31'h4000, 31'h4000});
        send_box('{32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                   31'h8000, 31'h8000, 31'h8000});
        send_box('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 31'h0, 31'h0, 31'h0});
    endtask

    // zero and full-scale reciprocals, origins at both ends of the range
    task automatic test_axis_extremes;
        want_lv = 32'hFFFF_FFFA;
        want_org = '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
        want_inv = '{32'h0000_0000, 32'hFFFF_FFFF, INV_RESET};
        load_space();
        send_box('{32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h1, 31'h0});
        send_box('{32'h7FFF_FFFF, 32'h0000_0003, 32'h7FFF_FFFF, 31'h0, 31'h0, 31'h8000});
        send_box('{32'h0000_0000, 32'h0000_0000, 32'h7FFF_0000, 31'h0, 31'h0, 31'h0});
        send_box('{32'hFFFF_0000, 32'h0000_0004, 32'h7FFF_FFFF, 31'h0, 31'h0, 31'h0});
        send_box('{32'h1234_5678, 32'h0000_0005, 32'h7FFF_FFFF, 31'h0, 31'h0, 31'h0});
    endtask

    // arbitrary register values, boxes random or offset upward from the configured origin
    task automatic test_random_config(input int n);
        box_t b;
        int   k;
        want_lv = $urandom;
        for (int a = 0; a < 3; a++)
        begin
            want_org[a] = $urandom;
            want_inv[a] = ($urandom_range(0, 4) == 0) ? 32'h0
                                                       : ($urandom >> $urandom_range(0, 31));
        end
        load_space();
        repeat (n)
        begin
            b = noise_box();
            if ($urandom_range(0, 1) == 0)
            begin
                k = $urandom_range(0, 31);
                b.cx = want_org[0] + ($urandom >> k);
                b.cy = want_org[1] + ($urandom >> k);
                b.cz = want_org[2] + ($urandom >> k);
                b.hx = b.hx >> $urandom_range(0, 30);
                b.hy = b.hy >> $urandom_range(0, 30);
                b.hz = b.hz >> $urandom_range(0, 30);
            end
            send_box(b);
        end
    endtask

    task automatic test_space_sweep(input int lv, input int n);
        set_space(lv);
        load_space();
        repeat (n)
            send_box(($urandom_range(0, 7) == 0) ? noise_box() : box_in_space(lv));
    endtask

    // full rate, no idle cycles
    task automatic test_back_to_back(input int n);
        gaps_on = 1'b0;
        set_space(MAX_LV);
        load_space();
        repeat (n)
            send_box(($urandom_range(0, 7) == 0) ? noise_box() : box_in_space(MAX_LV));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_zero_levels();
        test_axis_extremes();
        test_random_config(80);
        for (int lv = 0; lv <= MAX_LV; lv++)
            test_space_sweep(lv, 80);
        test_back_to_back(100);
        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ocib_pkg.sv
rtl/core/ocib_axis_quant.sv
rtl/core/ocib_index.sv
rtl/core/octree_cell_index_of_box_unit.sv
sim/octree_cell_index_of_box_unit_tb.sv
